[rtl/lrukv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam int          CAP_W     = 5;
	localparam logic [4:0]  CAP_RESET = 5'd16;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;    // load the input item
		logic lookup;    // register compare results
		logic update;    // apply table update
		logic load_out;  // write the result register
	} dp_cmd_t;

	typedef struct packed {
		logic is_get;    // item in flight is a get
		logic out_full;  // result register holds an untaken item
	} dp_status_t;

endpackage

[rtl/lru_key_value_cache_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     op, key, value
//  out      out_valid / out_stall   hit, read_value (gets only)
//  cfg      cfg_wr_en               cfg_wr_data (capacity)
//
// Each item goes through a parallel key compare across all slots, then the
// rank/table update. A new item is taken in the update cycle of the last.
// A get waits in its update cycle while the result register is full and stalled.
// Reset clears valid marks, count and result valid; capacity resets to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
	import lrukv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CAP_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] read_value
);

	dp_cmd_t    cmd;
	dp_status_t status;

	lrukv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lrukv_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value)
	);

endmodule

[rtl/lrukv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_ctrl
// Sequencer: accept, lookup cycle, update cycle; overlaps accept with update.
// ----------------------------------------------------------------------------
module lrukv_ctrl
	import lrukv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	logic        upd_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a get may only finish when the result register can take its item
	assign upd_done = !status.is_get || !status.out_full || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (upd_done) begin
					cmd.update   = 1'b1;
					cmd.load_out = status.is_get;
					in_stall     = 1'b0;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = ST_LOOKUP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/lrukv_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_datapath
// Key table with parallel compare, recency ranks and result register.
// ----------------------------------------------------------------------------
module lrukv_datapath
	import lrukv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               cfg_wr_en,
	input  logic [CAP_W-1:0]   cfg_wr_data,
	input  logic               op,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] read_value
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int UW = (CW > CAP_W) ? CW : CAP_W;

	// table
	logic [ENTRIES-1:0] valid_q;
	logic [31:0]        key_mem  [ENTRIES];
	logic [31:0]        val_mem  [ENTRIES];
	logic [IW-1:0]      rank_q   [ENTRIES];
	logic [CW-1:0]      count_q;
	logic [CAP_W-1:0]   cap_q;

	// item in flight
	logic        op_q;
	logic [31:0] key_q;
	logic [31:0] value_q;

	// lookup results
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic [31:0]   rd_value_q;
	logic          evict_q;
	logic [IW-1:0] victim_idx_q;
	logic [IW-1:0] free_idx_q;

	// result register
	logic        out_valid_q;
	logic        out_hit_q;
	logic [31:0] out_value_q;

	logic [ENTRIES-1:0] match_c;
	logic [ENTRIES-1:0] oldest_c;
	logic [ENTRIES-1:0] avail_c;
	logic               hit_c;
	logic [IW-1:0]      hit_idx_c;
	logic [IW-1:0]      victim_idx_c;
	logic [IW-1:0]      free_idx_c;
	logic [UW-1:0]      cap_ext;
	logic [UW-1:0]      ucap_c;
	logic [UW-1:0]      count_ext;
	logic [CW-1:0]      last_rank;
	logic               evict_c;

	always_comb begin
		cap_ext = UW'(cap_q);
		if (cap_ext == '0) begin
			ucap_c = UW'(1);
		end else if (cap_ext > UW'(ENTRIES)) begin
			ucap_c = UW'(ENTRIES);
		end else begin
			ucap_c = cap_ext;
		end
	end

	assign count_ext = UW'(count_q);
	assign evict_c   = (count_ext >= ucap_c);
	assign last_rank = count_q - CW'(1);

	// per-slot compares; least recent slot holds rank count-1
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_c[i]  = valid_q[i] && (key_mem[i] == key_q);
			oldest_c[i] = valid_q[i] && (CW'(rank_q[i]) == last_rank);
		end
	end

	always_comb begin
		hit_c        = 1'b0;
		hit_idx_c    = '0;
		victim_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_c[i]) begin
				hit_c     = 1'b1;
				hit_idx_c = IW'(i);
			end
			if (oldest_c[i]) begin
				victim_idx_c = IW'(i);
			end
		end
	end

	// lowest empty slot, counting the victim as empty when evicting
	always_comb begin
		avail_c    = ~valid_q | (evict_c ? oldest_c : '0);
		free_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (avail_c[i]) begin
				free_idx_c = IW'(i);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.update && op_q == OP_PUT && !hit_q) begin
				if (evict_q) begin
					valid_q[victim_idx_q] <= 1'b0;
				end else begin
					count_q <= count_q + CW'(1);
				end
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and table contents
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
		if (cmd.lookup) begin
			hit_q        <= hit_c;
			hit_idx_q    <= hit_idx_c;
			hit_rank_q   <= rank_q[hit_idx_c];
			rd_value_q   <= val_mem[hit_idx_c];
			evict_q      <= evict_c;
			victim_idx_q <= victim_idx_c;
			free_idx_q   <= free_idx_c;
		end
		if (cmd.update) begin
			if (hit_q) begin
				// touch: slots more recent than the hit age by one
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && IW'(i) != hit_idx_q && rank_q[i] < hit_rank_q) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				rank_q[hit_idx_q] <= '0;
				if (op_q == OP_PUT) begin
					val_mem[hit_idx_q] <= value_q;
				end
			end else if (op_q == OP_PUT) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				rank_q[free_idx_q]  <= '0;
				key_mem[free_idx_q] <= key_q;
				val_mem[free_idx_q] <= value_q;
			end
		end
		if (cmd.load_out) begin
			out_hit_q   <= hit_q;
			out_value_q <= hit_q ? rd_value_q : MISS_VALUE;
		end
	end

	assign status.is_get   = (op_q == OP_GET);
	assign status.out_full = out_valid_q;

	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign read_value = out_value_q;

endmodule

[tb/tb_lru_key_value_cache_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key/value cache. A shadow table with
// recency ranks predicts every lookup. Gets and puts are driven through the
// valid/stall channel under several capacity settings and idle patterns, and
// each returned lookup is compared against the prediction.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
	import lrukv_pkg::*;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic        hit;
		logic [31:0] value;
	} lookup_result_t;

	class cache_scoreboard;
		bit             slot_used[SLOTS];
		logic [31:0]    slot_key[SLOTS];
		logic [31:0]    slot_value[SLOTS];
		int unsigned    slot_rank[SLOTS];
		int unsigned    used_count;
		logic [4:0]     capacity;
		lookup_result_t lookups[$];
		int             errors;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 0;
				slot_rank[i] = 0;
			end
			used_count = 0;
			capacity   = CAP_RESET;
			errors     = 0;
		endfunction

		function void set_capacity(logic [4:0] c);
			capacity = c;
		endfunction

		function int pending();
			return lookups.size();
		endfunction

		function int find_slot(logic [31:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_key[i] == k)
					return i;
			return -1;
		endfunction

		// move slot s to rank 0; slots that were more recent age by one
		function void promote(int s);
			int unsigned r;
			r = slot_rank[s];
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && i != s && slot_rank[i] < r)
					slot_rank[i]++;
			slot_rank[s] = 0;
		endfunction

		function void evict_lru();
			int victim;
			victim = -1;
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
					victim = i;
			if (victim >= 0) begin
				slot_used[victim] = 0;
				if (used_count > 0)
					used_count--;
			end
		endfunction

		function void note_item(logic o, logic [31:0] k, logic [31:0] v);
			int             s;
			int             free_slot;
			int unsigned    limit;
			lookup_result_t r;
			s = find_slot(k);
			if (o == OP_GET) begin
				if (s >= 0) begin
					r.hit   = 1'b1;
					r.value = slot_value[s];
					promote(s);
				end else begin
					r.hit   = 1'b0;
					r.value = MISS_VALUE;
				end
				lookups.push_back(r);
				return;
			end
			if (s >= 0) begin
				slot_value[s] = v;
				promote(s);
				return;
			end
			limit = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
			// a lowered capacity only stops growth, it never shrinks the table
			if (used_count >= limit)
				evict_lru();
			free_slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_used[i])
					free_slot = i;
			if (free_slot < 0)
				return;
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i])
					slot_rank[i]++;
			slot_used[free_slot]  = 1;
			slot_key[free_slot]   = k;
			slot_value[free_slot] = v;
			slot_rank[free_slot]  = 0;
			used_count++;
		endfunction

		function void check_result(logic h, logic [31:0] rv);
			lookup_result_t e;
			if (lookups.size() == 0) begin
				$display("%0t: unexpected lookup result hit=%0b read_value=%h",
					$time, h, rv);
				errors++;
				return;
			end
			e = lookups.pop_front();
			if (h !== e.hit) begin
				$display("%0t: hit mismatch: expected %0b, actual %0b", $time, e.hit, h);
				errors++;
			end
			if (rv !== e.value) begin
				$display("%0t: read_value mismatch: expected %h, actual %h",
					$time, e.value, rv);
				errors++;
			end
		endfunction
	endclass

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0]   cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic               op          = OP_GET;
	logic signed [31:0] key         = '0;
	logic signed [31:0] value       = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic               hit;
	logic signed [31:0] read_value;

	cache_scoreboard sb;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              hold_req      = 0;
	int              hold_done     = 0;
	int              hold_left     = 0;
	int              cycles        = 0;
	logic [31:0]     key_pool[24];
	int              pool_size;

	lru_key_value_cache_top #(.ENTRIES(SLOTS)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_lru_key_value_cache_top failed");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// check the result first so a new item never pairs with an older output
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(hit, read_value);
			if (in_valid && !in_stall)
				sb.note_item(op, key, value);
		end
	end

	// called right after a rising edge; returns right after the accepting edge
	task automatic send_item(input logic o, input logic [31:0] k, input logic [31:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		key      <= k;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// a put leaves no result, so allow the block to finish its update cycle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] c);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= c;
		@(posedge clk);
		sb.set_capacity(c);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input logic [4:0] cap, input int n, input int s_idle,
		input int r_idle, input bit long_hold, input bit full_pause);
		int          eff;
		logic        o;
		logic [31:0] k;
		drain();
		write_capacity(cap);
		send_idle_pct = s_idle;
		recv_idle_pct <= r_idle;
		eff = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap;
		// a pool a little larger than the capacity gives both hits and evictions
		pool_size = eff + $urandom_range(1, 6);
		for (int i = 0; i < pool_size; i++)
			key_pool[i] = ($urandom_range(0, 7) == 0) ? pick_word() : $urandom;
		for (int i = 0; i < n; i++) begin
			if (long_hold && i == n / 3)
				hold_req <= hold_req + 1;
			if (full_pause && i == n / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			o = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
			if ($urandom_range(0, 99) < 88)
				k = key_pool[$urandom_range(0, pool_size - 1)];
			else
				k = $urandom;
			send_item(o, k, pick_word());
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table miss, extreme keys and values, overwrite
		send_item(OP_GET, 32'h0000_0000, 32'h0);
		send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_GET, 32'h8000_0000, 32'h0);
		send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
		send_item(OP_GET, 32'h0001_2345, 32'h0);
		send_item(OP_PUT, 32'h0000_0000, 32'h1234_5678);
		send_item(OP_GET, 32'h0000_0000, 32'h0);
		send_item(OP_GET, 32'h7FFF_FFFF, 32'h0);
		// capacity below the current count: new keys evict one each
		drain();
		write_capacity(5'd2);
		send_item(OP_PUT, 32'h0000_0011, 32'h0000_0005);
		send_item(OP_PUT, 32'h0000_0022, 32'h0000_0006);
		send_item(OP_GET, 32'h8000_0000, 32'h0);
		send_item(OP_GET, 32'h7FFF_FFFF, 32'h0);
		send_item(OP_GET, 32'h0000_0000, 32'h0);
		send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
		send_item(OP_GET, 32'h0000_0011, 32'h0);
		send_item(OP_GET, 32'h0000_0022, 32'h0);

		run_phase(5'd16, 200, 17, 77, 1'b0, 1'b0);
		run_phase(5'd4,  200, 17, 77, 1'b1, 1'b0);
		run_phase(5'd1,  200, 17, 77, 1'b0, 1'b0);
		run_phase(5'd31, 200, 77, 17, 1'b0, 1'b1);
		run_phase(5'd0,  200, 77, 17, 1'b0, 1'b0);
		run_phase(5'd2,  200, 77, 17, 1'b0, 1'b0);
		run_phase(5'd17, 200, 0,  0,  1'b1, 1'b0);
		run_phase(5'd8,  200, 0,  0,  1'b0, 1'b0);
		run_phase(5'd16, 200, 0,  0,  1'b0, 1'b1);

		drain();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected lookups never returned", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("tb_lru_key_value_cache_top passed");
		else
			$display("tb_lru_key_value_cache_top failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/lrukv_pkg.sv
rtl/lrukv_ctrl.sv
rtl/lrukv_datapath.sv
rtl/lru_key_value_cache_top.sv
tb/tb_lru_key_value_cache_top.sv
